### hw/rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the descending comb sort block.
// ----------------------------------------------------------------------------
package csd_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 16;

	// one stored list entry: the key and the tag that travels with it
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_READ,
		ST_CMP,
		ST_WR2,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} st_t;

	// gap shrink by 10/13 as a multiply by a scaled reciprocal: 50420 / 2^16
	localparam int GAP_MUL   = 50420;
	localparam int GAP_SHIFT = 16;

endpackage

### hw/rtl/csd_in_if.sv
// ----------------------------------------------------------------------------
// csd_in_if
// Input channel of the comb sort: one list entry per transfer.
// ----------------------------------------------------------------------------
interface csd_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [csd_pkg::KEY_W-1:0] key;
	logic [csd_pkg::TAG_W-1:0]        tag;
	logic                             last_in;

	modport source (output valid, key, tag, last_in, input ready);
	modport sink (input valid, key, tag, last_in, output ready);
endinterface

### hw/rtl/csd_out_if.sv
// ----------------------------------------------------------------------------
// csd_out_if
// Output channel of the comb sort: one sorted entry per transfer.
// ----------------------------------------------------------------------------
interface csd_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [csd_pkg::KEY_W-1:0] sorted_key;
	logic [csd_pkg::TAG_W-1:0]        sorted_tag;
	logic                             last_out;
	logic                             overflowed;

	modport source (output valid, sorted_key, sorted_tag, last_out, overflowed, input ready);
	modport sink (input valid, sorted_key, sorted_tag, last_out, overflowed, output ready);
endinterface

### hw/rtl/comb_sort_descending.sv
// ----------------------------------------------------------------------------
// comb_sort_descending
// Collects a keyed list and returns it in descending key order (comb sort).
// ----------------------------------------------------------------------------
// Entries are taken one per cycle into a MAX_ENTRIES deep store; entries that
// arrive while the store is full are dropped and every result of that list
// carries overflowed. After the entry marked last_in the block stops taking
// input and sorts in place with one shared compare-and-swap step: a read state
// fetches the pair, a compare state writes the earlier slot, and a further write
// state writes the later slot only when the pair swaps. The pass count follows
// the comb sort gap sequence plus the closing gap-one passes. Results then
// leave one at a time, each read from the store into the read register and
// held there until it is taken, the final one marked last_out. A list of one
// entry goes straight to output. Input is accepted again after the last
// result transfer.
module comb_sort_descending #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	csd_in_if.sink      items,
	csd_out_if.source   results
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int PROD_W = CNT_W + csd_pkg::GAP_SHIFT;

	// gap * 10 / 13, exact for gaps well beyond the parameter range
	function automatic logic [CNT_W-1:0] gap_shrink(input logic [CNT_W-1:0] g);
		logic [PROD_W-1:0] p;
		p = PROD_W'(g) * PROD_W'(csd_pkg::GAP_MUL);
		return CNT_W'(p >> csd_pkg::GAP_SHIFT);
	endfunction

	csd_pkg::st_t state_q, state_d;

	csd_pkg::entry_t mem_q [MAX_ENTRIES];
	csd_pkg::entry_t rd_a_q, rd_b_q;
	csd_pkg::entry_t wr_data;
	logic [IDX_W-1:0] wr_addr, rd_addr_a;
	logic             wr_en, rd_en;

	logic [CNT_W-1:0] count_q, gap_q, gap_in, gap_nx;
	logic [IDX_W-1:0] i_q, j_q, e_q;
	logic             ovf_q, swap_q;

	logic in_take, out_take, room, less, step_done, pass_end, emit_last;
	logic [CNT_W-1:0] count_after;

	// handshakes and compare
	assign in_take   = items.valid && items.ready;
	assign out_take  = results.valid && results.ready;
	assign room      = count_q < CNT_W'(MAX_ENTRIES);
	assign count_after = room ? count_q + CNT_W'(1) : count_q;
	assign less      = rd_a_q.key < rd_b_q.key;
	assign step_done = (state_q == csd_pkg::ST_CMP && !less) || state_q == csd_pkg::ST_WR2;
	assign pass_end  = CNT_W'(j_q) == count_q - CNT_W'(1);
	assign emit_last = CNT_W'(e_q) == count_q - CNT_W'(1);
	assign gap_in    = (state_q == csd_pkg::ST_START) ? count_q : gap_q;
	assign gap_nx    = gap_shrink(gap_in);

	// output channel driven from the read register
	assign items.ready        = state_q == csd_pkg::ST_LOAD;
	assign results.valid      = state_q == csd_pkg::ST_EMIT_OUT;
	assign results.sorted_key = rd_a_q.key;
	assign results.sorted_tag = rd_a_q.tag;
	assign results.last_out   = emit_last;
	assign results.overflowed = ovf_q;

	// store port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = rd_b_q;
		case (state_q)
			csd_pkg::ST_LOAD: begin
				wr_en        = in_take && room;
				wr_addr      = count_q[IDX_W-1:0];
				wr_data.key  = items.key;
				wr_data.tag  = items.tag;
			end
			csd_pkg::ST_CMP: begin
				wr_en   = less;
				wr_addr = i_q;
				wr_data = rd_b_q;
			end
			csd_pkg::ST_WR2: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = rd_a_q;
			end
			default: ;
		endcase
		rd_en     = state_q == csd_pkg::ST_READ || state_q == csd_pkg::ST_EMIT_RD;
		rd_addr_a = (state_q == csd_pkg::ST_EMIT_RD) ? e_q : i_q;
	end

	// entry store with registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[j_q];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csd_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csd_pkg::ST_LOAD: begin
				if (in_take && items.last_in) begin
					state_d = (count_after < CNT_W'(2)) ? csd_pkg::ST_EMIT_RD
						: csd_pkg::ST_START;
				end
			end
			csd_pkg::ST_START: state_d = csd_pkg::ST_READ;
			csd_pkg::ST_READ:  state_d = csd_pkg::ST_CMP;
			csd_pkg::ST_CMP, csd_pkg::ST_WR2: begin
				if (state_q == csd_pkg::ST_CMP && less) begin
					state_d = csd_pkg::ST_WR2;
				end else if (pass_end && gap_q <= CNT_W'(1) && !swap_q) begin
					state_d = csd_pkg::ST_EMIT_RD;
				end else begin
					state_d = csd_pkg::ST_READ;
				end
			end
			csd_pkg::ST_EMIT_RD: state_d = csd_pkg::ST_EMIT_OUT;
			csd_pkg::ST_EMIT_OUT: begin
				if (out_take) begin
					state_d = emit_last ? csd_pkg::ST_LOAD : csd_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = csd_pkg::ST_LOAD;
		endcase
	end

	// list count, gap and pair indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			gap_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			e_q     <= '0;
			swap_q  <= 1'b0;
		end else begin
			case (state_q)
				csd_pkg::ST_LOAD: begin
					e_q <= '0;
					if (in_take) begin
						count_q <= count_after;
						if (!room) begin
							ovf_q <= 1'b1;
						end
					end
				end
				csd_pkg::ST_START: begin
					gap_q  <= gap_nx;
					i_q    <= '0;
					j_q    <= IDX_W'(gap_nx);
					swap_q <= 1'b0;
				end
				csd_pkg::ST_CMP: begin
					if (less) begin
						swap_q <= 1'b1;
					end
				end
				csd_pkg::ST_EMIT_OUT: begin
					if (out_take) begin
						if (emit_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							e_q <= e_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase

			// advance to the next pair or start the next pass
			if (step_done) begin
				if (pass_end) begin
					i_q    <= '0;
					swap_q <= 1'b0;
					if (gap_q > CNT_W'(1)) begin
						gap_q <= gap_nx;
						j_q   <= IDX_W'(gap_nx);
					end else begin
						j_q <= IDX_W'(1);
					end
				end else begin
					i_q <= i_q + IDX_W'(1);
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

### tb/comb_sort_descending_test.sv
// ----------------------------------------------------------------------------
// comb_sort_descending_test
// Self-checking bench for the descending comb sort block.
// ----------------------------------------------------------------------------
// Lists of keyed entries go in over the item channel. A scoreboard keeps its
// own copy of the list store and runs the same comb sort gap sequence on every
// marked list. Each sorted transfer that leaves the block is checked in order
// against it. Directed lists cover single entries, extreme keys and tags, and
// equal keys. Random lists follow, some of them full or over capacity, under
// three back-pressure mixes. One long receiver hold-off and one sender pause
// until everything has drained are included.
// ----------------------------------------------------------------------------
module comb_sort_descending_test;

	localparam int KEY_W = csd_pkg::KEY_W;
	localparam int TAG_W = csd_pkg::TAG_W;

	localparam int          LIST_DEPTH     = 32;
	localparam int unsigned ITEMS_PER_MIX  = 155;
	localparam int unsigned HOLDOFF_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES    = 100;
	localparam int unsigned LIMIT_CYCLES   = 1000000;
	localparam int unsigned MAX_REPORTS    = 40;

	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [TAG_W-1:0]        TAG_MAX = '1;

	// how the keys of one random list are laid out
	typedef enum int {
		KEYS_WIDE,
		KEYS_NARROW,
		KEYS_EDGE,
		KEYS_RISING,
		KEYS_FALLING
	} key_style_t;

	// one expected sorted transfer
	typedef struct {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
		logic                    last;
		logic                    dropped;
	} sorted_entry_t;

	// list store copy, comb sort and in-order result check
	class sort_scoreboard;
		logic signed [KEY_W-1:0] list_key[LIST_DEPTH];
		logic [TAG_W-1:0]        list_tag[LIST_DEPTH];
		int unsigned             list_len;
		bit                      list_dropped;
		sorted_entry_t           sorted_q[$];
		int unsigned             errors;
		int unsigned             reports;
		int unsigned             entries_taken;
		int unsigned             lists_done;
		int unsigned             overflow_lists;
		int unsigned             results_checked;

		function int unsigned pending();
			return sorted_q.size();
		endfunction

		// descending comb sort of the first n stored entries, tags follow keys
		function void comb_sort_list(int unsigned n);
			int unsigned gap;
			int unsigned i;
			int unsigned swaps;
			logic signed [KEY_W-1:0] k;
			logic [TAG_W-1:0] t;
			if (n < 2)
				return;
			gap = n * 10 / 13;
			while (1) begin
				swaps = 0;
				for (i = 0; i + gap < n; i++) begin
					if (list_key[i] < list_key[i + gap]) begin
						k = list_key[i];
						t = list_tag[i];
						list_key[i] = list_key[i + gap];
						list_tag[i] = list_tag[i + gap];
						list_key[i + gap] = k;
						list_tag[i + gap] = t;
						swaps++;
					end
				end
				if (gap <= 1) begin
					if (swaps == 0)
						break;
				end else begin
					gap = gap * 10 / 13;
				end
			end
		endfunction

		// accepted entry: store it, and on the marked one queue the sorted list
		function void note_entry(logic signed [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic l);
			sorted_entry_t s;
			int unsigned i;
			entries_taken++;
			if (list_len < LIST_DEPTH) begin
				list_key[list_len] = k;
				list_tag[list_len] = t;
				list_len++;
			end else begin
				list_dropped = 1'b1;
			end
			if (!l)
				return;
			comb_sort_list(list_len);
			for (i = 0; i < list_len; i++) begin
				s.key = list_key[i];
				s.tag = list_tag[i];
				s.last = (i + 1 == list_len);
				s.dropped = list_dropped;
				sorted_q.push_back(s);
			end
			if (list_dropped)
				overflow_lists++;
			lists_done++;
			list_len = 0;
			list_dropped = 1'b0;
		endfunction

		function void report_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
			errors++;
			if (reports < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			reports++;
		endfunction

		// sorted transfer: compare with the oldest expectation
		function void check_result(logic signed [KEY_W-1:0] k, logic [TAG_W-1:0] t,
				logic l, logic o);
			sorted_entry_t want;
			results_checked++;
			if (sorted_q.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual key %0h tag %0h",
						$time, k, t);
				reports++;
				return;
			end
			want = sorted_q.pop_front();
			if (k !== want.key)
				report_field("sorted_key", want.key, k);
			if (t !== want.tag)
				report_field("sorted_tag", KEY_W'(want.tag), KEY_W'(t));
			if (l !== want.last)
				report_field("last_out", KEY_W'(want.last), KEY_W'(l));
			if (o !== want.dropped)
				report_field("overflowed", KEY_W'(want.dropped), KEY_W'(o));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	csd_in_if  items_ch();
	csd_out_if results_ch();

	comb_sort_descending #(
		.MAX_ENTRIES(LIST_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch)
	);

	sort_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          holdoff_req;
	int unsigned items_sent;
	int unsigned cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// transfer monitors on both channels
	always @(posedge clk) begin
		if (arst_n && items_ch.valid && items_ch.ready)
			sb.note_entry(items_ch.key, items_ch.tag, items_ch.last_in);
		if (arst_n && results_ch.valid && results_ch.ready)
			sb.check_result(results_ch.sorted_key, results_ch.sorted_tag,
				results_ch.last_out, results_ch.overflowed);
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				results_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else begin
				results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// offer one entry, idling cycle by cycle first, until it is taken
	task automatic send_entry(input logic signed [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
			input logic l);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid   <= 1'b1;
		items_ch.key     <= k;
		items_ch.tag     <= t;
		items_ch.last_in <= l;
		do @(posedge clk); while (!items_ch.ready);
		items_sent++;
	endtask

	// one random list of the given length and key layout
	task automatic send_list(input int unsigned len, input key_style_t style);
		logic signed [KEY_W-1:0] k;
		int unsigned i;
		int v;
		k = (style == KEYS_RISING) ? -50000 : 50000;
		for (i = 0; i < len; i++) begin
			case (style)
				KEYS_WIDE: begin
					k = $urandom;
				end
				KEYS_NARROW: begin
					v = $urandom_range(6);
					k = v - 3;
				end
				KEYS_EDGE: begin
					case ($urandom_range(3))
						0: k = KEY_MIN;
						1: k = KEY_MAX;
						2: k = -1;
						default: k = 0;
					endcase
				end
				KEYS_RISING: begin
					k = k + $urandom_range(0, 4000);
				end
				default: begin
					k = k - $urandom_range(0, 4000);
				end
			endcase
			send_entry(k, TAG_W'($urandom), i + 1 == len);
		end
	endtask

	// stop offering until every queued result has come back
	task automatic wait_until_drained();
		items_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// stimulus
	initial begin
		int unsigned mix;
		int unsigned mix_start;
		int unsigned r;
		int unsigned len;
		bit drained_once;
		arst_n           <= 1'b0;
		items_ch.valid   <= 1'b0;
		items_ch.key     <= '0;
		items_ch.tag     <= '0;
		items_ch.last_in <= 1'b0;
		holdoff_req   = 1'b0;
		items_sent    = 0;
		drained_once  = 1'b0;
		send_idle_pct = 20;
		recv_idle_pct = 58;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single entries pass through, extreme keys and tags
		send_entry(KEY_MAX, TAG_MAX, 1'b1);
		send_entry(KEY_MIN, '0, 1'b1);
		// pair in rising order must swap
		send_entry(KEY_MIN, 16'h0001, 1'b0);
		send_entry(KEY_MAX, 16'h0002, 1'b1);
		// equal keys keep their order
		send_entry(5, 16'haaaa, 1'b0);
		send_entry(5, 16'h5555, 1'b1);
		// mixed signs and extremes
		send_entry(-1, 16'h0010, 1'b0);
		send_entry(0, 16'h0011, 1'b0);
		send_entry(1, 16'h0012, 1'b0);
		send_entry(KEY_MAX, 16'h0013, 1'b0);
		send_entry(KEY_MIN, 16'h0014, 1'b0);
		send_entry(0, 16'h0015, 1'b1);
		// duplicates around the extremes
		send_entry(0, 16'h8000, 1'b0);
		send_entry(KEY_MIN, 16'h7fff, 1'b0);
		send_entry(0, 16'h0100, 1'b0);
		send_entry(KEY_MIN, TAG_MAX, 1'b0);
		send_entry(KEY_MAX, 16'h0000, 1'b1);

		// random lists under three back-pressure mixes
		for (mix = 0; mix < 3; mix++) begin
			case (mix)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					holdoff_req = 1'b1;
				end
			endcase
			mix_start = items_sent;
			// a full store, one over (last entry dropped), and well over
			case (mix)
				0: send_list(LIST_DEPTH, KEYS_WIDE);
				1: send_list(LIST_DEPTH + 1, KEYS_NARROW);
				default: send_list(LIST_DEPTH + 8, KEYS_RISING);
			endcase
			while (items_sent - mix_start < ITEMS_PER_MIX) begin
				r = $urandom_range(15);
				if (r == 0)
					len = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 8);
				else if (r < 4)
					len = $urandom_range(1, 2);
				else
					len = $urandom_range(3, 12);
				send_list(len, key_style_t'($urandom_range(4)));
				if (mix == 2 && !drained_once && items_sent - mix_start > 80) begin
					wait_until_drained();
					drained_once = 1'b1;
				end
			end
		end

		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d lists (%0d entries, %0d over capacity), checked %0d sorted results",
			sb.lists_done, sb.entries_taken, sb.overflow_lists, sb.results_checked);
		$display("back-pressure on both sides, one long result hold-off, one full drain pause");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results still expected", sb.errors, sb.pending());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/csd_pkg.sv
hw/rtl/csd_in_if.sv
hw/rtl/csd_out_if.sv
hw/rtl/comb_sort_descending.sv
tb/comb_sort_descending_test.sv
